// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PLB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/plb_pkg.sv
// Shared types and constants of the polyline length and bounds unit.
package plb_pkg;

  // Width of the accumulated path length, 8 fraction bits.
  localparam int unsigned LEN_W = 42;

  // Status of the segment length unit.
  typedef struct packed {
    logic busy;
    logic done;
  } plb_seg_stat_t;

endpackage

// File: rtl/plb_seglen.sv
// Bit-serial segment length: squares dx and dy, then takes the floor square root.
`include "assert_macros.svh"

module plb_seglen import plb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COORD_WIDTH-1:0] dx_i,
  input  logic [COORD_WIDTH-1:0] dy_i,
  output plb_seg_stat_t          stat_o,
  output logic [COORD_WIDTH:0]   root_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned SW  = 2 * W + 2;
  localparam int unsigned RW  = W + 3;
  localparam int unsigned RTW = W + 1;
  localparam int unsigned CW  = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SQR  = 3'b010,
    S_ROOT = 3'b100
  } seg_state_e;

  seg_state_e state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           done_q, done_d;
  logic [W-1:0]   bx_q, bx_d, by_q, by_d;
  logic [SW-1:0]  mx_q, mx_d, my_q, my_d;
  logic [SW-1:0]  acc_q, acc_d;
  logic [RW-1:0]  rem_q, rem_d;
  logic [RTW-1:0] root_q, root_d;

  logic [SW-1:0] add_x, add_y, acc_sum;
  logic [RW-1:0] rem_t, trial;
  logic          ge;

  always_comb begin
    add_x   = bx_q[0] ? mx_q : '0;
    add_y   = by_q[0] ? my_q : '0;
    acc_sum = acc_q + add_x + add_y;
    rem_t   = {rem_q[RW-3:0], acc_q[SW-1:SW-2]};
    trial   = {1'b0, root_q[RTW-2:0], 2'b01};
    ge      = (rem_t >= trial);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    bx_d    = bx_q;
    by_d    = by_q;
    mx_d    = mx_q;
    my_d    = my_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SQR;
          cnt_d   = CW'(W - 1);
          bx_d    = dx_i;
          by_d    = dy_i;
          mx_d    = SW'(dx_i);
          my_d    = SW'(dy_i);
          acc_d   = '0;
          rem_d   = '0;
          root_d  = '0;
        end
      end
      S_SQR: begin
        // one multiplier bit of each square per cycle
        acc_d = acc_sum;
        bx_d  = bx_q >> 1;
        by_d  = by_q >> 1;
        mx_d  = mx_q << 1;
        my_d  = my_q << 1;
        if (cnt_q == '0) begin
          state_d = S_ROOT;
          cnt_d   = CW'(W);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_ROOT: begin
        // restoring square root, one root bit per cycle
        acc_d  = acc_q << 2;
        rem_d  = ge ? (rem_t - trial) : rem_t;
        root_d = {root_q[RTW-2:0], ge};
        if (cnt_q == '0) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q   <= bx_d;
    by_q   <= by_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = done_q;
  assign root_o      = root_q;

  `PLB_ASSERT(a_start_idle, (start_i |-> state_q == S_IDLE), "seglen: start while busy")
  `PLB_ASSERT(a_done_pulse, (done_q |=> !done_q), "seglen: done longer than one cycle")
  `PLB_ASSERT(a_done_after_root, ($rose(done_q) |-> $past(state_q == S_ROOT)),
              "seglen: done without root phase")

endmodule

// File: rtl/polyline_length_and_bounds_unit.sv
// Top level of the polyline length and bounding box unit.
//
// Points of a 2-D polyline enter one item at a time as signed fixed-point
// coordinates with 8 fraction bits; last_point_i marks the final point of a
// curve. On that point one result item leaves with the bounding box, the
// summed segment length (floor square root of dx^2 + dy^2 per segment,
// saturating at 2^42-1) and the point count (saturating at MAX_POINTS), and
// the unit clears for the next curve. The first point of a curve opens it
// without segment work. Every later point goes through the bit-serial
// segment length unit: shift-and-add squaring, then restoring square root,
// one root bit per cycle, and such a point occupies the unit until its root
// is done. A final point then hands its result to the output register in
// ST_EMIT, which waits while an untaken result is held there. The output
// register holds a waiting result while the next point is already taken.
`include "assert_macros.svh"

module polyline_length_and_bounds_unit import plb_pkg::*; #(
  parameter int unsigned MAX_POINTS  = 65536,
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]        point_x_i,
  input  logic signed [COORD_WIDTH-1:0]        point_y_i,
  input  logic                                 last_point_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [COORD_WIDTH-1:0]        min_x_o,
  output logic signed [COORD_WIDTH-1:0]        max_x_o,
  output logic signed [COORD_WIDTH-1:0]        min_y_o,
  output logic signed [COORD_WIDTH-1:0]        max_y_o,
  output logic [LEN_W-1:0]                     path_length_o,
  output logic [$clog2(MAX_POINTS + 1)-1:0]    point_count_o
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned RTW   = W + 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  // Control sequence of one item.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,  // ready for a point
    ST_SEG  = 3'b010,  // segment length in flight
    ST_EMIT = 3'b100   // hand the curve summary to the output register
  } top_state_e;

  top_state_e state_q, state_d;
  logic have_prev_q, have_prev_d;
  logic last_q, last_d;
  logic [LEN_W-1:0] length_q, length_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic signed [W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [W-1:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic signed [W-1:0] min_y_q, min_y_d, max_y_q, max_y_d;

  logic out_valid_q, out_valid_d;
  logic signed [W-1:0] o_min_x_q, o_max_x_q, o_min_y_q, o_max_y_q;
  logic [LEN_W-1:0] o_length_q;
  logic [CNT_W-1:0] o_count_q;

  logic in_accept, seg_start, emit_ok;
  logic [W:0]       diff_x, diff_y;
  logic [W-1:0]     dx, dy;
  logic [LEN_W:0]   len_sum;
  logic [RTW-1:0]   seg_root;
  plb_seg_stat_t    seg_stat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign seg_start  = in_accept & have_prev_q;
  assign emit_ok    = (state_q == ST_EMIT) & (~out_valid_q | out_ready_i);

  // Absolute coordinate differences against the previous point.
  always_comb begin
    if (point_x_i >= prev_x_q) begin
      diff_x = {point_x_i[W-1], point_x_i} - {prev_x_q[W-1], prev_x_q};
    end else begin
      diff_x = {prev_x_q[W-1], prev_x_q} - {point_x_i[W-1], point_x_i};
    end
    if (point_y_i >= prev_y_q) begin
      diff_y = {point_y_i[W-1], point_y_i} - {prev_y_q[W-1], prev_y_q};
    end else begin
      diff_y = {prev_y_q[W-1], prev_y_q} - {point_y_i[W-1], point_y_i};
    end
    dx = diff_x[W-1:0];
    dy = diff_y[W-1:0];
  end

  plb_seglen #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_seglen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seg_start),
    .dx_i    (dx),
    .dy_i    (dy),
    .stat_o  (seg_stat),
    .root_o  (seg_root)
  );

  // Saturating add of the finished segment; the carry out marks overflow.
  assign len_sum = {1'b0, length_q} + (LEN_W + 1)'(seg_root);

  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    last_d      = last_q;
    length_d    = length_q;
    count_d     = count_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    min_x_d     = min_x_q;
    max_x_d     = max_x_q;
    min_y_d     = min_y_q;
    max_y_d     = max_y_q;
    out_valid_d = out_valid_q;

    // drop the output item once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          prev_x_d    = point_x_i;
          prev_y_d    = point_y_i;
          have_prev_d = 1'b1;
          last_d      = last_point_i;
          if (!have_prev_q) begin
            // open a new curve at this point
            min_x_d  = point_x_i;
            max_x_d  = point_x_i;
            min_y_d  = point_y_i;
            max_y_d  = point_y_i;
            length_d = '0;
            count_d  = CNT_W'(1);
            state_d  = last_point_i ? ST_EMIT : ST_IDLE;
          end else begin
            if (point_x_i < min_x_q) min_x_d = point_x_i;
            if (point_x_i > max_x_q) max_x_d = point_x_i;
            if (point_y_i < min_y_q) min_y_d = point_y_i;
            if (point_y_i > max_y_q) max_y_d = point_y_i;
            if (count_q != CNT_MAX) begin
              count_d = count_q + 1'b1;
            end
            state_d = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        if (seg_stat.done) begin
          length_d = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
          state_d  = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          // clear for the next curve
          have_prev_d = 1'b0;
          length_d    = '0;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      last_q      <= 1'b0;
      length_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      last_q      <= last_d;
      length_q    <= length_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_x_q <= prev_x_d;
    prev_y_q <= prev_y_d;
    min_x_q  <= min_x_d;
    max_x_q  <= max_x_d;
    min_y_q  <= min_y_d;
    max_y_q  <= max_y_d;
    if (emit_ok) begin
      o_min_x_q  <= min_x_q;
      o_max_x_q  <= max_x_q;
      o_min_y_q  <= min_y_q;
      o_max_y_q  <= max_y_q;
      o_length_q <= length_q;
      o_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_x_o       = o_min_x_q;
  assign max_x_o       = o_max_x_q;
  assign min_y_o       = o_min_y_q;
  assign max_y_o       = o_max_y_q;
  assign path_length_o = o_length_q;
  assign point_count_o = o_count_q;

  `PLB_ASSERT(a_seg_tracked, (state_q == ST_SEG |-> seg_stat.busy || seg_stat.done),
              "top: waiting on an idle segment unit")
  `PLB_ASSERT(a_out_from_emit, ($rose(out_valid_q) |-> $past(state_q == ST_EMIT)),
              "top: result item without emit")
  `PLB_ASSERT(a_len_monotonic,
              ((state_q == ST_SEG && seg_stat.done) |=> (length_q >= $past(length_q))),
              "top: path length decreased")

endmodule
